>>> rtl/core/sfmb_pkg.sv
// ---------------------------------------------------------------------------
// sfmb_pkg
// Shared types and codes for the serial frame memory bridge.
// ---------------------------------------------------------------------------
package sfmb_pkg;

   localparam logic [7:0] MAGIC_IN  = 8'h42;
   localparam logic [7:0] MAGIC_OUT = 8'h24;
   localparam logic [7:0] OP_READ   = 8'h01;
   localparam logic [7:0] OP_WRITE  = 8'h02;
   localparam logic [7:0] OP_ACK    = 8'h81;
   localparam logic [7:0] OP_NAK    = 8'h82;

   typedef enum logic [1:0] {
      CMD_NAK,
      CMD_READ,
      CMD_WRITE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  addr;
      logic [7:0]   count;
   } cmd_type;

   typedef struct packed {
      logic       en;
      logic [7:0] idx;
      logic [7:0] data;
   } pay_wr_type;

endpackage

>>> rtl/core/serial_frame_memory_bridge.sv
// ---------------------------------------------------------------------------
// serial_frame_memory_bridge
// Host byte frame parser with a byte-wide memory for reads and page writes.
// ---------------------------------------------------------------------------
// req_ channel: one host byte per transfer (req_func 0), or an inter-byte
// timeout (req_func 1) that drops a partial frame. rsp_ channel: response
// frame bytes, up to two per transfer, rsp_last_of_frame on the last pair.
// A transfer happens when valid is high and stall is low.
// Checked frames are queued (two deep) to the response engine, so the
// parser keeps taking bytes while a response drains.
// Response engine: each frame byte passes a fetch step (memory read), then
// a put step (pair assembly); a frame holds 6 + n bytes, and the receiver
// can stall it. A page write of L bytes first copies its payload into
// memory before its ACK. req_stall rises when the queue is full and when
// payload bytes arrive while a page write is pending.
// A stalled response pair holds in the output register; the engine waits.
// Reset returns to magic hunting and empties the queue; memory and payload
// contents are not cleared.
// ---------------------------------------------------------------------------
module serial_frame_memory_bridge #(
   parameter int PAYLOAD_BYTES = 64,
   parameter int PAGE_BYTES    = 64,
   parameter int MEM_BYTES     = 32768
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_first,
   output logic [7:0] rsp_tx_second,
   output logic       rsp_second_valid,
   output logic       rsp_last_of_frame
);
   import sfmb_pkg::*;

   logic       push_en;
   cmd_type    push_cmd;
   cmd_type    head;
   logic       q_empty;
   logic       q_full;
   logic       q_has_write;
   logic       pop_en;
   logic       copying;
   pay_wr_type pay_wr;

   sfmb_front #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .PAGE_BYTES   (PAGE_BYTES),
      .MEM_BYTES    (MEM_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_rx_byte(req_rx_byte),
      .push_en    (push_en),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .write_busy (q_has_write || copying),
      .pay_wr     (pay_wr)
   );

   sfmb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (push_en),
      .push_cmd (push_cmd),
      .pop_en   (pop_en),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full),
      .has_write(q_has_write)
   );

   sfmb_back #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .MEM_BYTES    (MEM_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_empty          (q_empty),
      .pop_en           (pop_en),
      .pay_wr           (pay_wr),
      .copying          (copying),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_first     (rsp_tx_first),
      .rsp_tx_second    (rsp_tx_second),
      .rsp_second_valid (rsp_second_valid),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

endmodule

>>> rtl/core/sfmb_front.sv
// ---------------------------------------------------------------------------
// sfmb_front
// Host frame parser: hunts magic, collects header and payload, checks the
// frame and queues one command per response frame.
// ---------------------------------------------------------------------------
module sfmb_front #(
   parameter int PAYLOAD_BYTES = 64,
   parameter int PAGE_BYTES    = 64,
   parameter int MEM_BYTES     = 32768
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [7:0]          req_rx_byte,
   output logic                push_en,
   output sfmb_pkg::cmd_type   push_cmd,
   input  logic                q_full,
   input  logic                write_busy,
   output sfmb_pkg::pay_wr_type pay_wr
);
   import sfmb_pkg::*;

   localparam int          RECIP_SHIFT = 24;
   localparam logic [24:0] RECIP = 25'((2 ** RECIP_SHIFT + PAGE_BYTES - 1) / PAGE_BYTES);

   typedef enum logic [2:0] {
      PH_HUNT, PH_CODE, PH_ALO, PH_AHI, PH_LEN, PH_DATA, PH_SUM
   } phase_type;

   phase_type   phase_ff;
   logic [7:0]  code_ff;
   logic [15:0] addr_ff;
   logic [7:0]  len_ff;
   logic [7:0]  idx_ff;
   logic [7:0]  chk_ff;
   logic [7:0]  rdn_ff;
   logic [15:0] quo_ff;

   logic        accept;
   logic        take;
   logic [40:0] prod;
   logic [15:0] quo_in;
   logic [15:0] page_rem;

   function automatic logic range_ok(logic [15:0] a, logic [7:0] n);
      range_ok = (n != 8'd0) && (9'(n) <= 9'(PAGE_BYTES)) &&
                 (17'(a) < 17'(MEM_BYTES)) &&
                 ((17'(a) + 17'(n)) <= 17'(MEM_BYTES));
   endfunction

   assign req_stall = q_full || ((phase_ff == PH_DATA) && write_busy);
   assign accept = req_valid && !req_stall;
   assign take   = accept && !req_func;

   // page offset by reciprocal multiply; the quotient is registered, and the
   // address settles before the checksum byte can arrive
   assign prod     = 41'(addr_ff) * 41'(RECIP);
   assign quo_in   = prod[RECIP_SHIFT +: 16];
   assign page_rem = addr_ff - 16'(23'(quo_ff) * 23'(PAGE_BYTES));

   always_comb begin
      push_en       = 1'b0;
      push_cmd.kind = CMD_NAK;
      push_cmd.addr = addr_ff;
      push_cmd.count = 8'd0;
      pay_wr.en     = 1'b0;
      pay_wr.idx    = idx_ff;
      pay_wr.data   = req_rx_byte;
      if (take) begin
         case (phase_ff)
            PH_LEN: begin
               push_en = req_rx_byte > 8'(PAYLOAD_BYTES);
            end
            PH_DATA: begin
               pay_wr.en = 1'b1;
            end
            PH_SUM: begin
               push_en = 1'b1;
               if (req_rx_byte == chk_ff) begin
                  if (code_ff == OP_READ) begin
                     if (len_ff == 8'd1 && 9'(rdn_ff) <= 9'(PAYLOAD_BYTES) &&
                         range_ok(addr_ff, rdn_ff)) begin
                        push_cmd.kind  = CMD_READ;
                        push_cmd.count = rdn_ff;
                     end
                  end else if (code_ff == OP_WRITE) begin
                     if (range_ok(addr_ff, len_ff) && page_rem == 16'd0) begin
                        push_cmd.kind  = CMD_WRITE;
                        push_cmd.count = len_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      if (reset) begin
         phase_ff <= PH_HUNT;
         code_ff  <= 8'd0;
         addr_ff  <= 16'd0;
         len_ff   <= 8'd0;
         idx_ff   <= 8'd0;
         chk_ff   <= 8'd0;
      end else begin
         if (accept && req_func) begin
            phase_ff <= PH_HUNT;
         end else if (take) begin
            case (phase_ff)
               PH_HUNT: begin
                  if (req_rx_byte == MAGIC_IN) begin
                     phase_ff <= PH_CODE;
                     chk_ff   <= MAGIC_IN;
                  end
               end
               PH_CODE: begin
                  code_ff  <= req_rx_byte;
                  chk_ff   <= chk_ff ^ req_rx_byte;
                  phase_ff <= PH_ALO;
               end
               PH_ALO: begin
                  addr_ff[7:0] <= req_rx_byte;
                  chk_ff       <= chk_ff ^ req_rx_byte;
                  phase_ff     <= PH_AHI;
               end
               PH_AHI: begin
                  addr_ff[15:8] <= req_rx_byte;
                  chk_ff        <= chk_ff ^ req_rx_byte;
                  phase_ff      <= PH_LEN;
               end
               PH_LEN: begin
                  chk_ff <= chk_ff ^ req_rx_byte;
                  if (req_rx_byte > 8'(PAYLOAD_BYTES)) begin
                     phase_ff <= PH_HUNT;
                  end else begin
                     len_ff   <= req_rx_byte;
                     idx_ff   <= 8'd0;
                     phase_ff <= (req_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (idx_ff == 8'd0) rdn_ff <= req_rx_byte;
                  chk_ff <= chk_ff ^ req_rx_byte;
                  idx_ff <= idx_ff + 8'd1;
                  if ((idx_ff + 8'd1) >= len_ff) phase_ff <= PH_SUM;
               end
               PH_SUM: begin
                  phase_ff <= PH_HUNT;
               end
               default: begin
                  phase_ff <= PH_HUNT;
               end
            endcase
         end
      end
   end

endmodule

>>> rtl/core/sfmb_queue.sv
// ---------------------------------------------------------------------------
// sfmb_queue
// Two-entry command queue between parser and response engine.
// ---------------------------------------------------------------------------
module sfmb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  sfmb_pkg::cmd_type push_cmd,
   input  logic              pop_en,
   output sfmb_pkg::cmd_type head,
   output logic              empty,
   output logic              full,
   output logic              has_write
);
   import sfmb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic [1:0] busy;

   assign head  = slot_ff[rp_ff];
   assign empty = cnt_ff == 2'd0;
   assign full  = cnt_ff == 2'd2;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         busy[i] = full || (cnt_ff == 2'd1 && rp_ff == 1'(i));
      end
      has_write = (busy[0] && slot_ff[0].kind == CMD_WRITE) ||
                  (busy[1] && slot_ff[1].kind == CMD_WRITE);
   end

   always_ff @(posedge clock) begin
      if (push_en) slot_ff[wp_ff] <= push_cmd;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_en) wp_ff <= ~wp_ff;
         if (pop_en) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push_en) - 2'(pop_en);
      end
   end

endmodule

>>> rtl/core/sfmb_back.sv
// ---------------------------------------------------------------------------
// sfmb_back
// Response engine: page-write copy into the memory array, response frame
// build and byte pairing into the output register.
// ---------------------------------------------------------------------------
module sfmb_back #(
   parameter int PAYLOAD_BYTES = 64,
   parameter int MEM_BYTES     = 32768
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sfmb_pkg::cmd_type    head,
   input  logic                 q_empty,
   output logic                 pop_en,
   input  sfmb_pkg::pay_wr_type pay_wr,
   output logic                 copying,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tx_first,
   output logic [7:0]           rsp_tx_second,
   output logic                 rsp_second_valid,
   output logic                 rsp_last_of_frame
);
   import sfmb_pkg::*;

   localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_CRD, S_CWR, S_FETCH, S_PUT
   } state_type;

   state_type  state_ff;
   cmd_type    cmd_ff;
   logic [7:0] cnt_ff;
   logic [7:0] pos_ff;
   logic [7:0] n_ff;
   logic       half_ff;
   logic [7:0] first_ff;
   logic [7:0] chk_ff;
   logic [7:0] pay_q_ff;
   logic [7:0] mem_q_ff;

   logic [7:0] pay_mem [PAYLOAD_BYTES];
   logic [7:0] mem     [MEM_BYTES];

   logic       mem_we;
   logic       mem_re;
   logic [AW-1:0] mem_wa;
   logic [AW-1:0] mem_ra;
   logic       last;
   logic       out_free;
   logic       emit;
   logic [7:0] cur;

   assign pop_en   = (state_ff == S_IDLE) && !q_empty;
   assign copying  = (state_ff == S_CRD) || (state_ff == S_CWR);
   assign mem_we   = state_ff == S_CWR;
   assign mem_wa   = AW'(17'(cmd_ff.addr) + 17'(cnt_ff));
   assign mem_re   = (state_ff == S_FETCH) && (pos_ff >= 8'd5) && (pos_ff < n_ff + 8'd5);
   assign mem_ra   = AW'(17'(cmd_ff.addr) + 17'(pos_ff) - 17'd5);
   assign last     = pos_ff == n_ff + 8'd5;
   assign out_free = !rsp_valid || !rsp_stall;
   assign emit     = (state_ff == S_PUT) && (half_ff || last) && out_free;

   always_comb begin
      case (pos_ff)
         8'd0: cur = MAGIC_OUT;
         8'd1: cur = (cmd_ff.kind == CMD_NAK) ? OP_NAK : OP_ACK;
         8'd2: cur = cmd_ff.addr[7:0];
         8'd3: cur = cmd_ff.addr[15:8];
         8'd4: cur = n_ff;
         default: cur = last ? chk_ff : mem_q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pay_wr.en) pay_mem[pay_wr.idx[PW-1:0]] <= pay_wr.data;
      if (state_ff == S_CRD) pay_q_ff <= pay_mem[cnt_ff[PW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= pay_q_ff;
      if (mem_re) mem_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         half_ff   <= 1'b0;
      end else begin
         if (emit) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= head;
                  cnt_ff   <= 8'd0;
                  pos_ff   <= 8'd0;
                  half_ff  <= 1'b0;
                  chk_ff   <= 8'd0;
                  n_ff     <= (head.kind == CMD_READ) ? head.count : 8'd0;
                  state_ff <= (head.kind == CMD_WRITE) ? S_CRD : S_FETCH;
               end
            end
            S_CRD: begin
               state_ff <= S_CWR;
            end
            S_CWR: begin
               cnt_ff   <= cnt_ff + 8'd1;
               state_ff <= ((cnt_ff + 8'd1) >= cmd_ff.count) ? S_FETCH : S_CRD;
            end
            S_FETCH: begin
               state_ff <= S_PUT;
            end
            S_PUT: begin
               if (!half_ff && !last) begin
                  first_ff <= cur;
                  chk_ff   <= chk_ff ^ cur;
                  half_ff  <= 1'b1;
                  pos_ff   <= pos_ff + 8'd1;
                  state_ff <= S_FETCH;
               end else if (out_free) begin
                  rsp_tx_first      <= half_ff ? first_ff : cur;
                  rsp_tx_second     <= half_ff ? cur : 8'd0;
                  rsp_second_valid  <= half_ff;
                  rsp_last_of_frame <= last;
                  chk_ff            <= chk_ff ^ cur;
                  half_ff           <= 1'b0;
                  pos_ff            <= pos_ff + 8'd1;
                  state_ff          <= last ? S_IDLE : S_FETCH;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> sim/tb_serial_frame_memory_bridge.sv
// ---------------------------------------------------------------------------
// tb_serial_frame_memory_bridge
// Self-checking bench for the serial frame memory bridge: host frames
// (reads, page writes, malformed frames, timeouts, noise) are sent, some
// under random idling; every response pair is compared with a local model.
// ---------------------------------------------------------------------------
module tb_serial_frame_memory_bridge;
   timeunit 1ns;
   timeprecision 1ps;

   import sfmb_pkg::*;

   class pair_scoreboard;
      typedef struct {
         logic [7:0] first;
         logic [7:0] second;
         logic       two;
         logic       last;
      } pair_type;

      typedef enum logic [2:0] {
         PH_HUNT, PH_CODE, PH_ALO, PH_AHI, PH_LEN, PH_DATA, PH_SUM
      } phase_type;

      pair_type   pending[$];
      phase_type  phase;
      logic [7:0] code;
      logic [15:0] addr;
      logic [7:0] len;
      logic [7:0] idx;
      logic [7:0] check;
      logic [7:0] payload[64];
      logic [7:0] mem[int];
      logic [7:0] frame[$];

      function new();
         phase = PH_HUNT;
         code = 8'h00;
         addr = 16'h0000;
         len = 8'h00;
         idx = 8'h00;
         check = 8'h00;
      endfunction

      function void send_frame(logic [7:0] rcode, logic [7:0] n, bit from_mem);
         logic [7:0] sum;
         pair_type p;
         frame.delete();
         frame.push_back(MAGIC_OUT);
         frame.push_back(rcode);
         frame.push_back(addr[7:0]);
         frame.push_back(addr[15:8]);
         frame.push_back(n);
         for (int i = 0; i < n; i++)
            frame.push_back(from_mem ? mem[int'(addr) + i] : 8'h00);
         sum = 8'h00;
         foreach (frame[i]) sum ^= frame[i];
         frame.push_back(sum);
         for (int i = 0; i < frame.size(); i += 2) begin
            p.first = frame[i];
            p.two = (i + 1) < frame.size();
            p.second = p.two ? frame[i + 1] : 8'h00;
            p.last = (i + 2) >= frame.size();
            pending.push_back(p);
         end
      endfunction

      function bit range_ok(int n);
         return n != 0 && n <= 64 && addr < 32768 && n <= 32768 - int'(addr);
      endfunction

      function void complete_frame();
         if (code == OP_READ) begin
            if (len != 1 || payload[0] > 64 || !range_ok(payload[0]))
               send_frame(OP_NAK, 8'd0, 1'b0);
            else send_frame(OP_ACK, payload[0], 1'b1);
         end else if (code == OP_WRITE) begin
            if (!range_ok(len) || addr[5:0] != 0) send_frame(OP_NAK, 8'd0, 1'b0);
            else begin
               for (int i = 0; i < len; i++) mem[int'(addr) + i] = payload[i];
               send_frame(OP_ACK, 8'd0, 1'b0);
            end
         end else send_frame(OP_NAK, 8'd0, 1'b0);
      endfunction

      function void note_input(logic func, logic [7:0] b);
         if (func) begin
            phase = PH_HUNT;
            return;
         end
         case (phase)
            PH_HUNT: if (b == MAGIC_IN) begin
               phase = PH_CODE;
               check = MAGIC_IN;
            end
            PH_CODE: begin
               code = b; check ^= b; phase = PH_ALO;
            end
            PH_ALO: begin
               addr[7:0] = b; check ^= b; phase = PH_AHI;
            end
            PH_AHI: begin
               addr[15:8] = b; check ^= b; phase = PH_LEN;
            end
            PH_LEN: begin
               check ^= b;
               if (b > 64) begin
                  phase = PH_HUNT;
                  send_frame(OP_NAK, 8'd0, 1'b0);
               end else begin
                  len = b; idx = 8'h00;
                  phase = (b == 0) ? PH_SUM : PH_DATA;
               end
            end
            PH_DATA: begin
               payload[idx[5:0]] = b; check ^= b; idx++;
               if (idx >= len) phase = PH_SUM;
            end
            default: begin
               phase = PH_HUNT;
               if (b != check) send_frame(OP_NAK, 8'd0, 1'b0);
               else complete_frame();
            end
         endcase
      endfunction

      function bit readable(int a, int n);
         for (int i = 0; i < n; i++) if (!mem.exists(a + i)) return 0;
         return 1;
      endfunction

      function bit check_pair(logic [7:0] f, logic [7:0] s, logic t, logic l,
                              output string msg);
         pair_type p;
         if (pending.size() == 0) begin
            msg = "unexpected response transfer";
            return 0;
         end
         p = pending.pop_front();
         if (f !== p.first || s !== p.second || t !== p.two || l !== p.last) begin
            $sformat(msg, "got %h %h %b %b want %h %h %b %b",
                     f, s, t, l, p.first, p.second, p.two, p.last);
            return 0;
         end
         return 1;
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tx_first;
   logic [7:0] rsp_tx_second;
   logic       rsp_second_valid;
   logic       rsp_last_of_frame;

   pair_scoreboard sb;
   int errors = 0;
   int cycles = 0;
   int send_idle;
   int recv_idle;
   logic [7:0] burst[$];

   serial_frame_memory_bridge dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string msg;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall)
         if (!sb.check_pair(rsp_tx_first, rsp_tx_second, rsp_second_valid,
                            rsp_last_of_frame, msg))
            report(msg);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_item(logic func, logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(func, b);
   endtask

   task automatic send_frame(logic [7:0] code, logic [15:0] a, logic [7:0] len,
                             bit bad_sum, bit rand_data, logic [7:0] rd_n);
      logic [7:0] sum;
      logic [7:0] b;
      burst.delete();
      burst.push_back(MAGIC_IN);
      burst.push_back(code);
      burst.push_back(a[7:0]);
      burst.push_back(a[15:8]);
      burst.push_back(len);
      if (len <= 64)
         for (int i = 0; i < len; i++) begin
            b = (i == 0 && code == OP_READ) ? rd_n :
                (rand_data ? 8'($urandom) : 8'hFF);
            burst.push_back(b);
         end
      sum = 8'h00;
      foreach (burst[i]) sum ^= burst[i];
      if (len <= 64) burst.push_back(bad_sum ? ~sum : sum);
      foreach (burst[i]) send_item(1'b0, burst[i]);
   endtask

   task automatic page_write(logic [15:0] a, logic [7:0] len);
      send_frame(OP_WRITE, a, len, 1'b0, 1'b1, 8'd0);
   endtask

   task automatic read_written(int n);
      int a;
      a = $urandom_range(1, 6) * 64 + $urandom_range(0, 63);
      if (!sb.readable(a, n)) a = 64;
      if (!sb.readable(a, n)) n = 1;
      send_frame(OP_READ, 16'(a), 8'd1, 1'b0, 1'b1, 8'(n));
   endtask

   task automatic random_frame();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         page_write(16'($urandom_range(1, 7) * 64), 8'($urandom_range(1, 32)));
      else if (pick < 70) read_written($urandom_range(1, 8));
      else if (pick < 76)
         send_frame(OP_READ, 16'h0040, 8'd1, 1'b0, 1'b1, 8'($urandom_range(65, 255)));
      else if (pick < 80)
         send_frame(OP_WRITE, 16'($urandom), 8'($urandom_range(0, 3)), 1'b0, 1'b1, 8'd0);
      else if (pick < 85)
         send_frame(8'($urandom), 16'($urandom), 8'($urandom_range(0, 3)),
                    1'b0, 1'b1, 8'd0);
      else if (pick < 89) send_frame(OP_READ, 16'h0040, 8'd1, 1'b1, 1'b1, 8'd1);
      else if (pick < 92)
         send_frame(OP_READ, 16'h0040, 8'($urandom_range(65, 255)), 1'b0, 1'b1, 8'd1);
      else if (pick < 96) begin
         send_item(1'b0, MAGIC_IN);
         send_item(1'b0, OP_READ);
         send_item(1'b1, 8'($urandom));
      end else send_item(1'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      sb = new();
      send_idle = 0;
      recv_idle = 0;
      reset = 1;
      req_valid = 0;
      req_func = 0;
      req_rx_byte = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      page_write(16'h0000, 8'd8);
      page_write(16'h7FC0, 8'd64);
      page_write(16'h0040, 8'd1);
      send_frame(OP_READ, 16'h7FC0, 8'd1, 1'b0, 1'b1, 8'd64);
      send_frame(OP_READ, 16'h7FFF, 8'd1, 1'b0, 1'b1, 8'd1);
      send_frame(OP_READ, 16'h7FC1, 8'd1, 1'b0, 1'b1, 8'd64);
      send_frame(OP_READ, 16'h0000, 8'd1, 1'b0, 1'b1, 8'd0);
      send_frame(OP_READ, 16'h0000, 8'd1, 1'b0, 1'b1, 8'd65);
      send_frame(OP_READ, 16'h8000, 8'd1, 1'b0, 1'b1, 8'd1);
      send_frame(OP_READ, 16'hFFFF, 8'd1, 1'b0, 1'b1, 8'd1);
      send_frame(OP_READ, 16'h0000, 8'd2, 1'b0, 1'b1, 8'd1);
      send_frame(OP_WRITE, 16'h0001, 8'd4, 1'b0, 1'b1, 8'd0);
      send_frame(OP_WRITE, 16'h0000, 8'd0, 1'b0, 1'b1, 8'd0);
      send_frame(OP_WRITE, 16'h8000, 8'd4, 1'b0, 1'b1, 8'd0);
      send_frame(8'hFF, 16'h1234, 8'd0, 1'b0, 1'b1, 8'd0);
      send_frame(OP_READ, 16'h0000, 8'd1, 1'b1, 1'b1, 8'd1);
      send_frame(OP_READ, 16'h0000, 8'hFF, 1'b0, 1'b1, 8'd1);
      send_frame(OP_READ, 16'h0000, 8'h41, 1'b0, 1'b1, 8'd1);
      send_item(1'b0, MAGIC_IN);
      send_item(1'b0, OP_WRITE);
      send_item(1'b1, 8'hFF);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 18 : (ph == 1) ? 75 : 0;
         recv_idle = (ph == 0) ? 75 : (ph == 1) ? 18 : 0;
         for (int k = 0; k < 3; k++) random_frame();
      end
      drain();

      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
